// File: src/lfa_pkg.sv
// Shared types and constants for the lowest-free identifier allocator.
package lfa_pkg;

    // Default pool size and the number of identifiers held by one cell.
    localparam int LFA_NUM_IDS = 256;
    localparam int LFA_GROUP   = 16;
    localparam int LFA_SLOT_W  = $clog2(LFA_GROUP);

    // Request modes.
    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_TEST    = 2'd2,
        MODE_FILL    = 2'd3
    } lfa_mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_DUP   = 2'd2
    } lfa_status_t;

    // Configuration register indexes.
    localparam logic [0:0] CFG_RANGE_FIRST = 1'b0;
    localparam logic [0:0] CFG_RANGE_LAST  = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH
    } lfa_state_t;

    // Broadcast command from the sequencer to every cell.
    typedef struct packed {
        logic fill;
        logic rel;
    } lfa_cmd_t;

    // Grant report from a cell that took the allocate token.
    typedef struct packed {
        logic                  hit;
        logic [LFA_SLOT_W-1:0] slot;
    } lfa_grant_t;

endpackage

// File: src/lfa_cell.sv
// One cell of the free-bitmap chain: a group of identifiers and the allocate token stage.
module lfa_cell #(
    parameter int NUM_IDS  = lfa_pkg::LFA_NUM_IDS,
    parameter int CELL_IDX = 0,
    parameter int CMP_W    = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lfa_pkg::lfa_cmd_t   cmd,
    input  logic [CMP_W-1:0]    id,
    input  logic [CMP_W-1:0]    lo,
    input  logic [CMP_W-1:0]    hi,
    input  logic                tok_in,
    output logic                tok_out,
    output logic                hit,
    output lfa_pkg::lfa_grant_t grant
);

    localparam int GROUP = lfa_pkg::LFA_GROUP;

    logic [GROUP-1:0] bits_reg;
    logic [GROUP-1:0] bits_next;
    logic             tok_reg;
    logic             tok_next;
    logic [GROUP-1:0] in_pool;
    logic [GROUP-1:0] id_match;
    logic [GROUP-1:0] set_mask;
    logic [GROUP-1:0] clr_mask;
    logic             any_free;
    logic [lfa_pkg::LFA_SLOT_W-1:0] low_slot;

    // Per-bit address decode against the broadcast id and the fill bounds.
    always_comb
    begin
        logic [CMP_W-1:0] g;
        for (int j = 0; j < GROUP; j++)
        begin
            g           = CMP_W'(CELL_IDX * GROUP + j);
            in_pool[j]  = (g < CMP_W'(NUM_IDS));
            id_match[j] = in_pool[j] && (g == id);
            set_mask[j] = (cmd.fill && in_pool[j] && (g >= lo) && (g <= hi))
                          || (cmd.rel && id_match[j]);
        end
    end

    // The input id is free when its bit is set here.
    assign hit = |(id_match & bits_reg);

    // Lowest free slot of this group.
    always_comb
    begin
        low_slot = '0;
        for (int j = GROUP - 1; j >= 0; j--)
        begin
            if (bits_reg[j])
            begin
                low_slot = lfa_pkg::LFA_SLOT_W'(j);
            end
        end
    end

    assign any_free = |bits_reg;

    // A token that finds a free slot stops here; otherwise it moves on next cycle.
    always_comb
    begin
        grant.hit  = tok_in && any_free;
        grant.slot = low_slot;
        clr_mask   = '0;
        if (grant.hit)
        begin
            clr_mask[low_slot] = 1'b1;
        end
        tok_next  = tok_in && !any_free;
        bits_next = (bits_reg | set_mask) & ~clr_mask;
    end

    assign tok_out = tok_reg;

    // Bitmap and token stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            tok_reg  <= 1'b0;
        end
        else
        begin
            bits_reg <= bits_next;
            tok_reg  <= tok_next;
        end
    end

endmodule

// File: src/lowest_free_id_allocator.sv
// Top level of the lowest-free identifier allocator: sequencer, configuration and cell chain.
//
// Channel   Direction  Handshake           Payload
// request   in         start && !busy      mode, id
// result    out        done (one cycle)    granted_id, is_free, status
// config    in         cfg_we              cfg_index, cfg_wdata
//
// Release, test and fill go from accept through the execute state to done; a new request may be
// accepted in the cycle done is high. Allocate walks a token along the chain of
// cells, one cell of LFA_GROUP identifiers per cycle, until the cell holding the lowest free
// id takes it; on an empty pool the token falls off the end and done reports EMPTY.
// Reset empties the pool at once; the result side cannot stall.
module lowest_free_id_allocator #(
    parameter int NUM_IDS = lfa_pkg::LFA_NUM_IDS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] mode,
    input  logic [7:0] id,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    output logic       done,
    output logic [7:0] granted_id,
    output logic       is_free,
    output logic [1:0] status
);

    localparam int GROUP = lfa_pkg::LFA_GROUP;
    localparam int CELLS = (NUM_IDS + GROUP - 1) / GROUP;
    localparam int GW    = $clog2(CELLS * GROUP);
    localparam int CMP_W = ((GW > 8) ? GW : 8) + 1;

    lfa_pkg::lfa_state_t  state_reg, state_next;
    lfa_pkg::lfa_mode_t   mode_reg;
    logic [7:0]           id_reg;
    logic [7:0]           first_reg;
    logic [7:0]           last_reg;
    logic                 was_free_reg, was_free_next;
    logic                 done_reg, done_next;
    logic [7:0]           granted_reg, granted_next;
    logic                 is_free_reg, is_free_next;
    lfa_pkg::lfa_status_t status_reg, status_next;

    lfa_pkg::lfa_cmd_t    cmd;
    logic [CMP_W-1:0]     id_w;
    logic [CMP_W-1:0]     lo_w;
    logic [CMP_W-1:0]     hi_w;
    logic [CELLS:0]       tok;
    logic [CELLS-1:0]     hits;
    lfa_pkg::lfa_grant_t  grants [CELLS];
    logic                 any_hit;
    logic                 any_grant;
    logic [CMP_W-1:0]     grant_id;
    logic                 exec;

    assign exec = (state_reg == lfa_pkg::ST_EXEC);

    // Broadcast command and operands for the cells.
    assign cmd.fill = exec && (mode_reg == lfa_pkg::MODE_FILL);
    assign cmd.rel  = exec && (mode_reg == lfa_pkg::MODE_RELEASE);
    assign tok[0]   = exec && (mode_reg == lfa_pkg::MODE_ALLOC);
    assign id_w     = CMP_W'(id_reg);
    assign lo_w     = CMP_W'((first_reg < last_reg) ? first_reg : last_reg);
    assign hi_w     = CMP_W'((first_reg < last_reg) ? last_reg : first_reg);

    // The chain of cells.
    for (genvar c = 0; c < CELLS; c++)
    begin : g_cell
        lfa_cell #(
            .NUM_IDS  (NUM_IDS),
            .CELL_IDX (c),
            .CMP_W    (CMP_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .id      (id_w),
            .lo      (lo_w),
            .hi      (hi_w),
            .tok_in  (tok[c]),
            .tok_out (tok[c+1]),
            .hit     (hits[c]),
            .grant   (grants[c])
        );
    end

    // Collect the availability of the id and the granted identifier.
    always_comb
    begin
        any_hit   = |hits;
        any_grant = 1'b0;
        grant_id  = '0;
        for (int c = 0; c < CELLS; c++)
        begin
            if (grants[c].hit)
            begin
                any_grant = 1'b1;
                grant_id  = grant_id | (CMP_W'(c * GROUP) + CMP_W'(grants[c].slot));
            end
        end
    end

    // Sequencer next state and result values.
    always_comb
    begin
        state_next    = state_reg;
        was_free_next = was_free_reg;
        done_next     = 1'b0;
        granted_next  = '0;
        is_free_next  = is_free_reg;
        status_next   = lfa_pkg::STAT_OK;
        case (state_reg)
            lfa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lfa_pkg::ST_EXEC;
                end
            end
            lfa_pkg::ST_EXEC:
            begin
                was_free_next = any_hit;
                is_free_next  = any_hit;
                if (mode_reg != lfa_pkg::MODE_ALLOC)
                begin
                    done_next  = 1'b1;
                    state_next = lfa_pkg::ST_IDLE;
                    if (mode_reg == lfa_pkg::MODE_RELEASE && any_hit)
                    begin
                        status_next = lfa_pkg::STAT_DUP;
                    end
                end
                else if (any_grant)
                begin
                    done_next    = 1'b1;
                    granted_next = grant_id[7:0];
                    state_next   = lfa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lfa_pkg::ST_SEARCH;
                end
            end
            lfa_pkg::ST_SEARCH:
            begin
                is_free_next = was_free_reg;
                if (any_grant)
                begin
                    done_next    = 1'b1;
                    granted_next = grant_id[7:0];
                    state_next   = lfa_pkg::ST_IDLE;
                end
                else if (tok[CELLS])
                begin
                    // The token fell off the end of the chain: the pool is empty.
                    done_next   = 1'b1;
                    status_next = lfa_pkg::STAT_EMPTY;
                    state_next  = lfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfa_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            first_reg <= 8'd0;
            last_reg  <= 8'd255;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we && cfg_index == lfa_pkg::CFG_RANGE_FIRST)
            begin
                first_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == lfa_pkg::CFG_RANGE_LAST)
            begin
                last_reg <= cfg_wdata;
            end
        end
    end

    // Request capture and result payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == lfa_pkg::ST_IDLE && start)
        begin
            mode_reg <= lfa_pkg::lfa_mode_t'(mode);
            id_reg   <= id;
        end
        was_free_reg <= was_free_next;
        granted_reg  <= granted_next;
        is_free_reg  <= is_free_next;
        status_reg   <= status_next;
    end

    assign busy       = (state_reg != lfa_pkg::ST_IDLE);
    assign done       = done_reg;
    assign granted_id = granted_reg;
    assign is_free    = is_free_reg;
    assign status     = status_reg;

endmodule
